### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros, included by ple_ctrl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// opcodes, status codes, micro-op codes and controller/datapath structs
// ----------------------------------------------------------------------------
package ple_pkg;

    typedef logic [3:0] t_opcode;
    localparam t_opcode OP_INS_START = 4'd0;
    localparam t_opcode OP_INS_END   = 4'd1;
    localparam t_opcode OP_INS_POS   = 4'd2;
    localparam t_opcode OP_DEL_POS   = 4'd3;
    localparam t_opcode OP_DEL_VALUE = 4'd4;
    localparam t_opcode OP_UPDATE    = 4'd5;
    localparam t_opcode OP_SEARCH    = 4'd6;
    localparam t_opcode OP_ROTATE    = 4'd7;
    localparam t_opcode OP_GET       = 4'd8;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_RANGE   = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_NOMATCH = 2'd3;

    typedef logic [4:0] t_uop;
    localparam t_uop UOP_NONE        = 5'd0;
    localparam t_uop UOP_LOAD        = 5'd1;
    localparam t_uop UOP_SET_RANGE   = 5'd2;
    localparam t_uop UOP_SET_FULL    = 5'd3;
    localparam t_uop UOP_SET_NOMATCH = 5'd4;
    localparam t_uop UOP_INS_PRIME   = 5'd5;
    localparam t_uop UOP_DEL_PRIME   = 5'd6;
    localparam t_uop UOP_SHIFT       = 5'd7;
    localparam t_uop UOP_INS_PUT     = 5'd8;
    localparam t_uop UOP_DROP        = 5'd9;
    localparam t_uop UOP_SCAN_INIT   = 5'd10;
    localparam t_uop UOP_SCAN        = 5'd11;
    localparam t_uop UOP_PUT_UPD     = 5'd12;
    localparam t_uop UOP_DIV_INIT    = 5'd13;
    localparam t_uop UOP_DIV         = 5'd14;
    localparam t_uop UOP_REV_INIT    = 5'd15;
    localparam t_uop UOP_REV_NEXT    = 5'd16;
    localparam t_uop UOP_SWP_A       = 5'd17;
    localparam t_uop UOP_SWP_B       = 5'd18;
    localparam t_uop UOP_SWP_C       = 5'd19;
    localparam t_uop UOP_SWP_D       = 5'd20;
    localparam t_uop UOP_GET_RD      = 5'd21;
    localparam t_uop UOP_GET_CAP     = 5'd22;
    localparam t_uop UOP_EMIT        = 5'd23;

    typedef struct packed {
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    ins_range;
        logic    full;
        logic    ins_shift;
        logic    pos_range;
        logic    cnt_zero;
        logic    n_zero;
        logic    del_noshift;
        logic    shift_last;
        logic    shift_down;
        logic    scan_hit;
        logic    scan_miss;
        logic    div_done;
        logic    k_zero;
        logic    rev_more;
        logic    rev_last;
        logic    out_free;
    } t_dp_stat;

endpackage

### rtl/core/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if
// command and response channels of the list engine
// ----------------------------------------------------------------------------
interface ple_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [15:0] position;
    logic [31:0] data_value;
    logic [15:0] rotate_count;

    modport source(output valid, opcode, position, data_value, rotate_count, input ready);
    modport sink(input valid, opcode, position, data_value, rotate_count, output ready);
endinterface

interface ple_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        found;
    logic [8:0]  entry_total;
    logic [1:0]  status;

    modport source(output valid, read_data, found, entry_total, status, input ready);
    modport sink(input valid, read_data, found, entry_total, status, output ready);
endinterface

### rtl/core/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// sequencer: decodes a command word and steps the datapath through it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ple_pkg::t_dp_stat  i_stat,
    output ple_pkg::t_dp_cmd   o_cmd
);
    import ple_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_DPRIME = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_PUT    = 4'd4;
    localparam logic [3:0] S_DROP   = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_KCHK   = 4'd8;
    localparam logic [3:0] S_RA     = 4'd9;
    localparam logic [3:0] S_RB     = 4'd10;
    localparam logic [3:0] S_RC     = 4'd11;
    localparam logic [3:0] S_RD     = 4'd12;
    localparam logic [3:0] S_GET    = 4'd13;
    localparam logic [3:0] S_FINISH = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_uop       w_uop;

    always_comb begin
        n_state = r_state;
        w_uop   = UOP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_uop   = UOP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                unique case (i_stat.op) inside
                    OP_INS_START, OP_INS_END, OP_INS_POS: begin
                        if (i_stat.ins_range) begin
                            w_uop = UOP_SET_RANGE;
                        end else if (i_stat.full) begin
                            w_uop = UOP_SET_FULL;
                        end else if (i_stat.ins_shift) begin
                            w_uop   = UOP_INS_PRIME;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    OP_DEL_POS: begin
                        if (i_stat.pos_range) begin
                            w_uop = UOP_SET_RANGE;
                        end else begin
                            n_state = S_DPRIME;
                        end
                    end
                    OP_DEL_VALUE, OP_SEARCH: begin
                        if (i_stat.cnt_zero) begin
                            if (i_stat.op == OP_DEL_VALUE) w_uop = UOP_SET_NOMATCH;
                        end else begin
                            w_uop   = UOP_SCAN_INIT;
                            n_state = S_SCAN;
                        end
                    end
                    OP_UPDATE: begin
                        w_uop = i_stat.pos_range ? UOP_SET_RANGE : UOP_PUT_UPD;
                    end
                    OP_ROTATE: begin
                        if (!i_stat.cnt_zero && !i_stat.n_zero) begin
                            w_uop   = UOP_DIV_INIT;
                            n_state = S_DIV;
                        end
                    end
                    OP_GET: begin
                        if (i_stat.pos_range) begin
                            w_uop = UOP_SET_RANGE;
                        end else begin
                            w_uop   = UOP_GET_RD;
                            n_state = S_GET;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_DPRIME: begin
                w_uop   = UOP_DEL_PRIME;
                n_state = i_stat.del_noshift ? S_DROP : S_SHIFT;
            end
            S_SHIFT: begin
                w_uop = UOP_SHIFT;
                if (i_stat.shift_last) n_state = i_stat.shift_down ? S_PUT : S_DROP;
            end
            S_PUT: begin
                w_uop   = UOP_INS_PUT;
                n_state = S_FINISH;
            end
            S_DROP: begin
                w_uop   = UOP_DROP;
                n_state = S_FINISH;
            end
            S_SCAN: begin
                w_uop = UOP_SCAN;
                if (i_stat.scan_hit) begin
                    n_state = (i_stat.op == OP_DEL_VALUE) ? S_DPRIME : S_FINISH;
                end else if (i_stat.scan_miss) begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                w_uop = UOP_DIV;
                if (i_stat.div_done) n_state = S_KCHK;
            end
            S_KCHK: begin
                if (i_stat.k_zero) begin
                    n_state = S_FINISH;
                end else begin
                    w_uop   = UOP_REV_INIT;
                    n_state = S_RA;
                end
            end
            S_RA: begin
                // three reversals: head part, tail part, whole list
                if (i_stat.rev_more) begin
                    w_uop   = UOP_SWP_A;
                    n_state = S_RB;
                end else if (i_stat.rev_last) begin
                    n_state = S_FINISH;
                end else begin
                    w_uop = UOP_REV_NEXT;
                end
            end
            S_RB: begin
                w_uop   = UOP_SWP_B;
                n_state = S_RC;
            end
            S_RC: begin
                w_uop   = UOP_SWP_C;
                n_state = S_RD;
            end
            S_RD: begin
                w_uop   = UOP_SWP_D;
                n_state = S_RA;
            end
            S_GET: begin
                w_uop   = UOP_GET_CAP;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    w_uop   = UOP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.uop  = w_uop;

    `ASSERT_CLK(a_accept_decode, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_DECODE), "accepted word not decoded")
    `ASSERT_NEVER(a_emit_free, i_clk, i_rst_n, (o_cmd.uop == UOP_EMIT) && !i_stat.out_free, "result emitted over a pending word")
    `ASSERT_CLK(a_shift_stays, i_clk, i_rst_n, (r_state == S_SHIFT && !i_stat.shift_last) |=> (r_state == S_SHIFT), "shift left early")

endmodule

### rtl/core/ple_dpath.sv
// ----------------------------------------------------------------------------
// ple_dpath
// list store, walk counters, remainder unit and result register
// ----------------------------------------------------------------------------
module ple_dpath #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_opcode,
    input  logic [15:0]        i_position,
    input  logic [31:0]        i_data_value,
    input  logic [15:0]        i_rotate_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_read_data,
    output logic               o_found,
    output logic [8:0]         o_entry_total,
    output logic [1:0]         o_status,
    input  ple_pkg::t_dp_cmd   i_cmd,
    output ple_pkg::t_dp_stat  o_stat
);
    import ple_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    t_opcode           r_op;
    logic [15:0]       r_pos;
    logic [DATA_W-1:0] r_val;
    logic [15:0]       r_n;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_stop;
    logic              r_down;
    logic              r_chk;
    logic [CW-1:0]     r_rem;
    logic [3:0]        r_bit;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [1:0]        r_phase;
    logic [DATA_W-1:0] r_tmp;
    logic [DATA_W-1:0] r_rd;
    logic              r_found;
    t_status           r_st;
    logic              r_ov;
    logic [31:0]       r_o_rd;
    logic              r_o_found;
    logic [8:0]        r_o_total;
    t_status           r_o_st;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [31:0]       w_ipos;
    logic [31:0]       w_pos32;
    logic [31:0]       w_cnt32;
    logic [CW-1:0]     w_i_next;
    logic [CW-1:0]     w_hi_m1;
    logic [CW:0]       w_trial;
    logic [CW-1:0]     w_rem_next;
    logic [63:0]       w_in64;
    logic [63:0]       w_rd64;
    logic              w_hit;
    logic              w_miss;
    logic              w_out_free;

    assign w_pos32 = 32'(r_pos);
    assign w_cnt32 = 32'(r_cnt);
    assign w_in64  = {32'd0, i_data_value};
    assign w_rd64  = 64'(r_rd);
    assign w_hi_m1 = r_hi - CW'(1);

    always_comb begin
        case (r_op)
            OP_INS_START: w_ipos = 32'd0;
            OP_INS_END:   w_ipos = w_cnt32;
            default:      w_ipos = w_pos32;
        endcase
    end

    assign w_i_next = r_down ? (r_i - CW'(1)) : (r_i + CW'(1));
    assign w_hit    = r_chk && (r_rdata == r_val);
    assign w_miss   = !w_hit && r_chk && (r_i == r_cnt);

    // restoring remainder step, one bit of the rotate count per cycle
    assign w_trial    = {r_rem, r_n[r_bit]};
    assign w_rem_next = (w_trial >= {1'b0, r_cnt}) ? CW'(w_trial - {1'b0, r_cnt})
                                                   : w_trial[CW-1:0];

    assign w_out_free = !r_ov || i_ready;

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_val;
        w_raddr = '0;
        unique case (i_cmd.uop)
            UOP_INS_PRIME: w_raddr = AW'(r_cnt - CW'(1));
            UOP_DEL_PRIME: w_raddr = AW'(r_pos + 16'd1);
            UOP_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_rdata;
                w_raddr = r_down ? AW'(w_i_next - CW'(1)) : AW'(w_i_next + CW'(1));
            end
            UOP_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = w_ipos[AW-1:0];
            end
            UOP_PUT_UPD: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
            end
            UOP_SCAN:   w_raddr = r_i[AW-1:0];
            UOP_SWP_A:  w_raddr = r_lo[AW-1:0];
            UOP_SWP_B:  w_raddr = w_hi_m1[AW-1:0];
            UOP_SWP_C: begin
                w_we    = 1'b1;
                w_waddr = r_lo[AW-1:0];
                w_wdata = r_rdata;
            end
            UOP_SWP_D: begin
                w_we    = 1'b1;
                w_waddr = w_hi_m1[AW-1:0];
                w_wdata = r_tmp;
            end
            UOP_GET_RD: w_raddr = r_pos[AW-1:0];
            default:    w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    // result register valid: set on emit, cleared when the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.uop == UOP_EMIT) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.uop)
                UOP_LOAD: begin
                    r_op    <= i_opcode;
                    r_pos   <= i_position;
                    r_val   <= w_in64[DATA_W-1:0];
                    r_n     <= i_rotate_count;
                    r_rd    <= '0;
                    r_found <= 1'b0;
                    r_st    <= ST_OK;
                end
                UOP_SET_RANGE:   r_st <= ST_RANGE;
                UOP_SET_FULL:    r_st <= ST_FULL;
                UOP_SET_NOMATCH: r_st <= ST_NOMATCH;
                UOP_INS_PRIME: begin
                    r_i    <= r_cnt;
                    r_stop <= CW'(w_ipos);
                    r_down <= 1'b1;
                end
                UOP_DEL_PRIME: begin
                    r_i    <= CW'(r_pos);
                    r_stop <= r_cnt - CW'(1);
                    r_down <= 1'b0;
                end
                UOP_SHIFT:   r_i <= w_i_next;
                UOP_INS_PUT: r_cnt <= r_cnt + CW'(1);
                UOP_DROP:    r_cnt <= r_cnt - CW'(1);
                UOP_SCAN_INIT: begin
                    r_i   <= '0;
                    r_chk <= 1'b0;
                end
                UOP_SCAN: begin
                    if (w_hit) begin
                        if (r_op == OP_SEARCH) r_found <= 1'b1;
                        r_pos <= 16'(r_i - CW'(1));
                    end else if (w_miss) begin
                        if (r_op == OP_DEL_VALUE) r_st <= ST_NOMATCH;
                    end else begin
                        r_i   <= r_i + CW'(1);
                        r_chk <= 1'b1;
                    end
                end
                UOP_DIV_INIT: begin
                    r_rem <= '0;
                    r_bit <= 4'd15;
                end
                UOP_DIV: begin
                    r_rem <= w_rem_next;
                    r_bit <= r_bit - 4'd1;
                end
                UOP_REV_INIT: begin
                    r_phase <= 2'd0;
                    r_lo    <= '0;
                    r_hi    <= r_rem;
                end
                UOP_REV_NEXT: begin
                    r_phase <= r_phase + 2'd1;
                    r_lo    <= (r_phase == 2'd0) ? r_rem : '0;
                    r_hi    <= r_cnt;
                end
                UOP_SWP_B: r_tmp <= r_rdata;
                UOP_SWP_D: begin
                    r_lo <= r_lo + CW'(1);
                    r_hi <= w_hi_m1;
                end
                UOP_GET_CAP: r_rd <= r_rdata;
                UOP_EMIT: begin
                    r_o_rd    <= w_rd64[31:0];
                    r_o_found <= r_found;
                    r_o_total <= w_cnt32[8:0];
                    r_o_st    <= r_st;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.op          = r_op;
        o_stat.ins_range   = w_ipos > w_cnt32;
        o_stat.full        = w_cnt32 >= 32'(DEPTH);
        o_stat.ins_shift   = w_ipos < w_cnt32;
        o_stat.pos_range   = w_pos32 >= w_cnt32;
        o_stat.cnt_zero    = (r_cnt == '0);
        o_stat.n_zero      = (r_n == 16'd0);
        o_stat.del_noshift = (w_pos32 + 32'd1) >= w_cnt32;
        o_stat.shift_last  = (w_i_next == r_stop);
        o_stat.shift_down  = r_down;
        o_stat.scan_hit    = w_hit;
        o_stat.scan_miss   = w_miss;
        o_stat.div_done    = (r_bit == 4'd0);
        o_stat.k_zero      = (r_rem == '0);
        o_stat.rev_more    = (32'(r_lo) + 32'd1) < 32'(r_hi);
        o_stat.rev_last    = (r_phase == 2'd2);
        o_stat.out_free    = w_out_free;
    end

    assign o_valid       = r_ov;
    assign o_read_data   = r_o_rd;
    assign o_found       = r_o_found;
    assign o_entry_total = r_o_total;
    assign o_status      = r_o_st;

endmodule

### rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of up to DEPTH values with positional and search operations
// ----------------------------------------------------------------------------
// i_cmd takes one command word (opcode, position, data_value, rotate_count);
// o_rsp returns one result word per command (read_data, found, entry_total,
// status). Both use valid/ready; a word moves when both are high.
// A command is taken only while the sequencer is idle; one command is worked
// at a time against a list memory with one write port and one read port.
// Work per command, n = entries held:
//   get, update, range or full errors, unused opcodes: no walk over the list
//   insert at p: p..n-1 move up one; delete at p: p+1..n-1 move down one
//   search / delete by value: up to n entries compared, plus the delete walk on a hit
//   rotate: remainder of rotate_count by n, then three reversal passes
// The insert, delete and search walks move or compare one entry a cycle.
// Reset empties the list at once; memory contents are not cleared.
// The result sits in an output register; a new command is accepted while it
// waits, and a stalled receiver only holds the next result back.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ple_in_if.sink       i_cmd,
    ple_out_if.source    o_rsp
);
    import ple_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ple_dpath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_cmd.opcode),
        .i_position     (i_cmd.position),
        .i_data_value   (i_cmd.data_value),
        .i_rotate_count (i_cmd.rotate_count),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_read_data    (o_rsp.read_data),
        .o_found        (o_rsp.found),
        .o_entry_total  (o_rsp.entry_total),
        .o_status       (o_rsp.status),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat)
    );

endmodule

### tb/tb_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_list_checker
// watches the command and response channels, models the list and compares
// every response word field by field against the predicted one
// ----------------------------------------------------------------------------
module tb_list_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ple_in_if.sink      i_cmd,
    ple_out_if.sink     i_rsp,
    output int          o_fail_count,
    output int          o_pending
);
    import ple_pkg::*;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic [31:0] read_data;
        logic        found;
        logic [8:0]  entry_total;
        t_status     status;
    } t_rsp_word;

    logic [31:0] list_model [DEPTH];
    int          list_len;
    t_rsp_word   rsp_queue [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = rsp_queue.size();

    function automatic t_status list_insert(int pos, logic [31:0] v);
        if (pos > list_len) return ST_RANGE;
        if (list_len >= DEPTH) return ST_FULL;
        for (int i = list_len; i > pos; i--) list_model[i] = list_model[i-1];
        list_model[pos] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic t_status list_delete(int pos);
        if (pos >= list_len) return ST_RANGE;
        for (int i = pos; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
        list_len--;
        return ST_OK;
    endfunction

    function automatic t_rsp_word list_apply(t_opcode op, int pos, logic [31:0] v, int n);
        t_rsp_word r;
        logic [31:0] tmp [DEPTH];
        int k;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INS_START: r.status = list_insert(0, v);
            OP_INS_END:   r.status = list_insert(list_len, v);
            OP_INS_POS:   r.status = list_insert(pos, v);
            OP_DEL_POS:   r.status = list_delete(pos);
            OP_DEL_VALUE: begin
                r.status = ST_NOMATCH;
                for (int i = 0; i < list_len; i++) begin
                    if (list_model[i] == v) begin
                        r.status = list_delete(i);
                        break;
                    end
                end
            end
            OP_UPDATE: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else list_model[pos] = v;
            end
            OP_SEARCH: begin
                for (int i = 0; i < list_len; i++)
                    if (list_model[i] == v) r.found = 1'b1;
            end
            OP_ROTATE: begin
                if (list_len != 0 && n != 0) begin
                    k = n % list_len;
                    for (int i = 0; i < list_len; i++) tmp[i] = list_model[(i + k) % list_len];
                    for (int i = 0; i < list_len; i++) list_model[i] = tmp[i];
                end
            end
            OP_GET: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else r.read_data = list_model[pos];
            end
            default: ;
        endcase
        r.entry_total = list_len[8:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp_word want;
        if (!i_rst_n) begin
            list_len = 0;
            rsp_queue.delete();
            fails = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_queue.size() == 0) begin
                    $error("response word with no command waiting");
                    fails++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp.read_data !== want.read_data) begin
                        $error("read_data expected %0h actual %0h", want.read_data, i_rsp.read_data);
                        fails++;
                    end
                    if (i_rsp.found !== want.found) begin
                        $error("found expected %0d actual %0d", want.found, i_rsp.found);
                        fails++;
                    end
                    if (i_rsp.entry_total !== want.entry_total) begin
                        $error("entry_total expected %0d actual %0d",
                               want.entry_total, i_rsp.entry_total);
                        fails++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_rsp.status);
                        fails++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                rsp_queue.push_back(list_apply(i_cmd.opcode, int'(i_cmd.position),
                                               i_cmd.data_value, int'(i_cmd.rotate_count)));
        end
    end
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random list commands with random gaps and response
// stalls; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
    import ple_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   live_len;
    logic [31:0] seen_vals [$];

    ple_in_if  cmd_if ();
    ple_out_if rsp_if ();

    positional_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source)
    );

    tb_list_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if.sink),
        .i_rsp        (rsp_if.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls; some stretches run with ready held high
    initial begin
        int stall_mode;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall_mode = $urandom_range(0, 9);
            if (stall_mode < 2) begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(50, 400)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= ($urandom_range(0, 2) != 0);
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(t_opcode op, logic [15:0] pos, logic [31:0] v, logic [15:0] n);
        int g;
        g = gap_len();
        if (g > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.position     <= pos;
        cmd_if.data_value   <= v;
        cmd_if.rotate_count <= n;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        // track length for shaping only
        case (op)
            OP_INS_START, OP_INS_END: if (live_len < 256) live_len++;
            OP_INS_POS: if (pos <= live_len && live_len < 256) live_len++;
            OP_DEL_POS: if (pos < live_len) live_len--;
            default: ;
        endcase
        if (op <= OP_INS_POS) seen_vals.push_back(v);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        if (seen_vals.size() != 0 && $urandom_range(0, 2) != 0)
            return seen_vals[$urandom_range(0, seen_vals.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [15:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom());
        if (r == 1) return 16'(live_len);
        return 16'($urandom_range(0, (live_len > 0) ? live_len : 0));
    endfunction

    initial begin
        t_opcode op;
        int      r;
        live_len = 0;
        i_rst_n <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.opcode       <= OP_INS_START;
        cmd_if.position     <= '0;
        cmd_if.data_value   <= '0;
        cmd_if.rotate_count <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list and small list corner cases
        send_word(OP_DEL_VALUE, 16'd0, 32'h0, 16'd0);
        send_word(OP_ROTATE, 16'd0, 32'h0, 16'd5);
        send_word(OP_GET, 16'd0, 32'h0, 16'd0);
        send_word(OP_INS_POS, 16'd1, 32'h1, 16'd0);
        send_word(OP_INS_START, 16'd0, 32'hFFFF_FFFF, 16'd0);
        send_word(OP_INS_END, 16'hFFFF, 32'h0000_0000, 16'hFFFF);
        send_word(OP_INS_POS, 16'd1, 32'hA5A5_5A5A, 16'd0);
        send_word(OP_INS_END, 16'd0, 32'hA5A5_5A5A, 16'd0);
        send_word(OP_SEARCH, 16'd0, 32'hA5A5_5A5A, 16'd0);
        send_word(OP_SEARCH, 16'd0, 32'h1234_5678, 16'd0);
        send_word(OP_DEL_VALUE, 16'd0, 32'hA5A5_5A5A, 16'd0);
        send_word(OP_UPDATE, 16'd2, 32'h5555_AAAA, 16'd0);
        send_word(OP_UPDATE, 16'hFFFF, 32'h1, 16'd0);
        send_word(OP_GET, 16'd2, 32'h0, 16'd0);
        send_word(OP_GET, 16'd3, 32'h0, 16'd0);
        send_word(OP_ROTATE, 16'd0, 32'h0, 16'd0);
        send_word(OP_ROTATE, 16'd0, 32'h0, 16'd3);
        send_word(OP_ROTATE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_DEL_POS, 16'd3, 32'h0, 16'd0);
        send_word(OP_DEL_POS, 16'd0, 32'h0, 16'd0);
        send_word(t_opcode'(4'd9), 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(t_opcode'(4'd15), 16'd0, 32'h0, 16'd0);
        drain();

        // fill to capacity, check the full case, rotate and read, drain, then delete down to four entries
        while (live_len < 256) send_word(OP_INS_END, 16'd0, $urandom(), 16'd0);
        send_word(OP_INS_START, 16'd0, 32'h7, 16'd0);
        send_word(OP_INS_POS, 16'd256, 32'h7, 16'd0);
        send_word(OP_INS_POS, 16'd257, 32'h7, 16'd0);
        send_word(OP_ROTATE, 16'd0, 32'h0, 16'd256);
        send_word(OP_ROTATE, 16'd0, 32'h0, 16'd255);
        send_word(OP_GET, 16'd255, 32'h0, 16'd0);
        drain();
        while (live_len > 4) send_word(OP_DEL_POS, 16'(pick_pos() % live_len), 32'h0, 16'd0);
        seen_vals.delete();

        for (int i = 0; i < 1216; i++) begin
            if (i == 600) drain();
            r = $urandom_range(0, 99);
            if (r < 30 && live_len < 40)      op = t_opcode'($urandom_range(0, 2));
            else if (r < 40)                 op = OP_DEL_POS;
            else if (r < 50)                 op = OP_DEL_VALUE;
            else if (r < 60)                 op = OP_UPDATE;
            else if (r < 72)                 op = OP_SEARCH;
            else if (r < 80)                 op = OP_ROTATE;
            else if (r < 97)                 op = OP_GET;
            else                             op = t_opcode'($urandom_range(0, 15));
            send_word(op, pick_pos(), pick_value(),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 50)));
            if (seen_vals.size() > 64) void'(seen_vals.pop_front());
        end
        drain();
        repeat (1200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("positional_list_engine verification clean");
        end else begin
            $display("positional_list_engine verification failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("positional_list_engine verification failed");
        $finish;
    end
endmodule
